>>> hw/rtl/tcw_pkg.sv
// Shared constants, types and helpers of the text console character writer.
package tcw_pkg;

   localparam int COLUMNS  = 40;
   localparam int ROWS     = 29;
   localparam int CELLS    = COLUMNS * ROWS;

   localparam int POS_W    = 11;
   localparam int CODE_W   = 16;
   localparam int LINE_W   = 6;
   localparam int IDX_W    = 11;
   localparam int FLAG_W   = 21;
   localparam int WORD_W   = 32;
   localparam int CSR_W    = 21;
   localparam int CSR_A_W  = 2;

   localparam int AW       = $clog2(CELLS);
   localparam int SW       = $clog2(CELLS + 1);
   localparam int CW       = (SW > POS_W) ? SW : POS_W;

   localparam int RECIP_SH = 20;
   localparam int RECIP    = ((1 << RECIP_SH) + COLUMNS - 1) / COLUMNS;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int QPROD_W  = POS_W + RECIP_W;
   localparam int COL_W    = $clog2(COLUMNS + 1);
   localparam int PROD_W   = POS_W + COL_W;

   localparam logic [WORD_W-1:0] ATTR_WORD   = 32'h3f00_0000;
   localparam logic [CODE_W-1:0] ENTER_RESET = 16'd13;
   localparam logic [CODE_W-1:0] TAB_RESET   = 16'd9;
   localparam logic [CODE_W-1:0] BS_RESET    = 16'd8;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_ENTER,
      CSR_TAB,
      CSR_BS,
      CSR_FLAGS
   } csr_idx_type;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_SCROLL,
      CMD_READ,
      CMD_NOP
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ENTER,
      KIND_TAB,
      KIND_BS,
      KIND_PLAIN
   } kind_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_TAB,
      CUR_ENTER,
      CUR_DEC,
      CUR_SCROLL
   } cur_op_type;

   typedef enum logic [1:0] {
      WV_ATTR,
      WV_RAW,
      WV_ZERO
   } wval_type;

   typedef struct packed {
      logic       accept;
      logic       load_q;
      logic       rd_cur;
      logic       rd_idx;
      logic       wr_cur;
      wval_type   wval;
      cur_op_type cur_op;
      logic       sweep_start;
      logic       sweep_clear;
      logic       scroll_one;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      kind_type kind;
      logic     lines_ok;
      logic     idx_ok;
      logic     need_scroll;
      logic     rd_zero;
      logic     cur_zero;
      logic     sweep_busy;
      logic     rsp_busy;
   } dp_stat_type;

   function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
      return v[AW-1:0];
   endfunction

endpackage

>>> hw/rtl/text_console_char_writer.sv
// Top level of the text console character writer.
//
// Text-mode console over a COLUMNS x ROWS store of 32-bit cells with an
// 11-bit cursor. One request beat on req_* gives exactly one response beat
// on rsp_*. req_tuser carries the command: put character, scroll lines,
// read cell or no-op. Register writes on csr_* take effect at the clock edge;
// the user must make them while the block is idle; the block does not check.
// Work from request beat to response beat:
//   plain character or tab: write; enter: reciprocal multiply, then rebuild;
//   backspace: a read and a check for every empty cell walked over;
//   read cell, invalid scroll, no-op: straight to the response;
//   scroll, or a put that reaches the end of the screen: a sweep of the
//   store, one cell per cycle through its single read and write port.
// One item is worked at a time; req_tready is high only in the idle state.
// The response sits in an output register, so a stalled receiver holds it
// while the next request is taken; that request completes once the
// register is free.
// After reset the store is cleared by a sweep with req_tready low; the
// cursor is zero and registers take their defaults.
module text_console_char_writer import tcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,   // char_code, line_count, cell_index, zero fill
   input  logic [1:0]         req_tuser,   // cmd
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // cursor_word, cell_data
   output logic               rsp_tuser,   // accepted
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   dp_cmd_type          dp_cmd;
   dp_stat_type         dp_stat;
   logic [WORD_W-1:0]   cursor_word;
   logic [WORD_W-1:0]   cell_data;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   tcw_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (cmd_type'(req_tuser)),
      .req_char_code   (req_tdata[15:0]),
      .req_line_count  (req_tdata[21:16]),
      .req_cell_index  (req_tdata[32:22]),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_tready),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_accepted    (rsp_tuser),
      .rsp_cursor_word (cursor_word),
      .rsp_cell_data   (cell_data)
   );

   assign rsp_tdata = {cell_data, cursor_word};

endmodule

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1160,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console character writer.
module tcw_ctrl import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_CLR_WAIT,
      S_IDLE,
      S_DECODE,
      S_ENTER,
      S_BS_RD,
      S_BS_CHK,
      S_POST,
      S_SWEEP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_clear = 1'b1;
            state_in        = S_CLR_WAIT;
         end
         S_CLR_WAIT: begin
            if (!stat.sweep_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.cmd)
               CMD_PUT: begin
                  unique case (stat.kind)
                     KIND_ENTER: begin
                        cmd.load_q = 1'b1;
                        state_in   = S_ENTER;
                     end
                     KIND_TAB: begin
                        cmd.wr_cur = 1'b1;
                        cmd.wval   = WV_RAW;
                        cmd.cur_op = CUR_TAB;
                        state_in   = S_POST;
                     end
                     KIND_BS: begin
                        state_in = S_BS_RD;
                     end
                     KIND_PLAIN: begin
                        cmd.wr_cur = 1'b1;
                        cmd.wval   = WV_ATTR;
                        cmd.cur_op = CUR_INC;
                        state_in   = S_POST;
                     end
                  endcase
               end
               CMD_SCROLL: begin
                  if (stat.lines_ok) begin
                     cmd.sweep_start = 1'b1;
                     cmd.cur_op      = CUR_SCROLL;
                     state_in        = S_SWEEP;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               CMD_READ: begin
                  cmd.rd_idx = stat.idx_ok;
                  state_in   = S_FINISH;
               end
               CMD_NOP: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ENTER: begin
            cmd.cur_op = CUR_ENTER;
            state_in   = S_POST;
         end
         S_BS_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_BS_CHK;
         end
         S_BS_CHK: begin
            if (!stat.cur_zero && stat.rd_zero) begin
               cmd.cur_op = CUR_DEC;
               state_in   = S_BS_RD;
            end else begin
               cmd.wr_cur = 1'b1;
               cmd.wval   = WV_ZERO;
               state_in   = S_POST;
            end
         end
         S_POST: begin
            if (stat.need_scroll) begin
               cmd.sweep_start = 1'b1;
               cmd.scroll_one  = 1'b1;
               cmd.cur_op      = CUR_SCROLL;
               state_in        = S_SWEEP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            if (!stat.sweep_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> hw/rtl/tcw_dpath.sv
// Datapath of the text console character writer: registers, cursor, cell store, sweep.
module tcw_dpath import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             req_cmd,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic [LINE_W-1:0]   req_line_count,
   input  logic [IDX_W-1:0]    req_cell_index,
   input  logic                csr_we,
   input  logic [CSR_A_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]    csr_wdata,
   input  logic                rsp_ready,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   output logic                rsp_valid,
   output logic                rsp_accepted,
   output logic [WORD_W-1:0]   rsp_cursor_word,
   output logic [WORD_W-1:0]   rsp_cell_data
);

   cmd_type             cmd_ff, cmd_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [LINE_W-1:0]   lines_ff, lines_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [POS_W-1:0]    q_ff, q_in;
   logic [POS_W-1:0]    cur_ff, cur_in;
   logic [CODE_W-1:0]   enter_ff, enter_in;
   logic [CODE_W-1:0]   tab_ff, tab_in;
   logic [CODE_W-1:0]   bs_ff, bs_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic                sweep_ff, sweep_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [CW-1:0]       shift_ff, shift_in;
   logic                wpend_ff, wpend_in;
   logic [AW-1:0]       waddr_ff, waddr_in;
   logic                wsrc_ff, wsrc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [LINE_W-1:0]   lines_sel;
   logic [CW-1:0]       shift_new;
   logic [CW-1:0]       cur_ext;
   logic                cur_in_range;
   logic                idx_ok;
   logic                lines_ok;
   logic [QPROD_W-1:0]  q_prod;
   logic [POS_W-1:0]    enter_pos;
   logic [POS_W-1:0]    scroll_pos;
   logic                ok_new;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [WORD_W-1:0]   ram_rdata;
   logic [WORD_W-1:0]   cur_wval;

   tcw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      lines_sel    = cmd.scroll_one ? LINE_W'(1) : lines_ff;
      shift_new    = CW'(lines_sel) * CW'(COLUMNS);
      cur_ext      = CW'(cur_ff);
      cur_in_range = cur_ext < CW'(CELLS);
      idx_ok       = CW'(idx_ff) < CW'(CELLS);
      lines_ok     = (lines_ff != '0) && (lines_ff <= LINE_W'(ROWS));
      q_prod       = QPROD_W'(cur_ff) * QPROD_W'(RECIP);
      enter_pos    = POS_W'((PROD_W'(q_ff) + PROD_W'(1)) * PROD_W'(COLUMNS));
      scroll_pos   = (cur_ext > shift_new) ? POS_W'(cur_ext - shift_new) : '0;
   end

   always_comb begin
      stat.cmd = cmd_ff;
      if (code_ff == enter_ff) begin
         stat.kind = KIND_ENTER;
      end else if (code_ff == tab_ff) begin
         stat.kind = KIND_TAB;
      end else if (code_ff == bs_ff) begin
         stat.kind = KIND_BS;
      end else begin
         stat.kind = KIND_PLAIN;
      end
      stat.lines_ok    = lines_ok;
      stat.idx_ok      = idx_ok;
      stat.need_scroll = !cur_in_range;
      stat.rd_zero     = !cur_in_range || (ram_rdata == '0);
      stat.cur_zero    = (cur_ff == '0);
      stat.sweep_busy  = sweep_ff || wpend_ff;
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // cell store access: sweep owns both ports while running
   always_comb begin
      case (cmd.wval)
         WV_ATTR: cur_wval = ATTR_WORD | WORD_W'(code_ff);
         WV_RAW:  cur_wval = WORD_W'(code_ff);
         default: cur_wval = '0;
      endcase
      ram_re    = (sweep_ff && (cnt_ff < keep_ff)) || cmd.rd_cur || cmd.rd_idx;
      if (sweep_ff) begin
         ram_raddr = to_addr(cnt_ff + shift_ff);
      end else if (cmd.rd_idx) begin
         ram_raddr = to_addr(CW'(idx_ff));
      end else begin
         ram_raddr = to_addr(cur_ext);
      end
      ram_we    = wpend_ff || (cmd.wr_cur && cur_in_range);
      ram_waddr = wpend_ff ? waddr_ff : to_addr(cur_ext);
      if (wpend_ff) begin
         ram_wdata = wsrc_ff ? ram_rdata : '0;
      end else begin
         ram_wdata = cur_wval;
      end
   end

   always_comb begin
      cmd_in   = cmd_ff;
      code_in  = code_ff;
      lines_in = lines_ff;
      idx_in   = idx_ff;
      if (cmd.accept) begin
         cmd_in   = req_cmd;
         code_in  = req_char_code;
         lines_in = req_line_count;
         idx_in   = req_cell_index;
      end

      q_in = cmd.load_q ? POS_W'(q_prod >> RECIP_SH) : q_ff;

      case (cmd.cur_op)
         CUR_INC:    cur_in = cur_ff + POS_W'(1);
         CUR_TAB:    cur_in = (cur_ff | POS_W'(3)) + POS_W'(1);
         CUR_ENTER:  cur_in = enter_pos;
         CUR_DEC:    cur_in = cur_ff - POS_W'(1);
         CUR_SCROLL: cur_in = scroll_pos;
         default:    cur_in = cur_ff;
      endcase

      enter_in = enter_ff;
      tab_in   = tab_ff;
      bs_in    = bs_ff;
      flags_in = flags_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_ENTER: enter_in = csr_wdata[CODE_W-1:0];
            CSR_TAB:   tab_in   = csr_wdata[CODE_W-1:0];
            CSR_BS:    bs_in    = csr_wdata[CODE_W-1:0];
            CSR_FLAGS: flags_in = csr_wdata[FLAG_W-1:0];
         endcase
      end

      // copy kept rows down, then zero the rest
      sweep_in = sweep_ff;
      cnt_in   = cnt_ff;
      keep_in  = keep_ff;
      shift_in = shift_ff;
      if (cmd.sweep_start) begin
         sweep_in = 1'b1;
         cnt_in   = '0;
         shift_in = shift_new;
         keep_in  = cmd.sweep_clear ? '0 : CW'(CELLS) - shift_new;
      end else if (sweep_ff) begin
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(CELLS - 1)) begin
            sweep_in = 1'b0;
         end
      end
      wpend_in = sweep_ff;
      waddr_in = to_addr(cnt_ff);
      wsrc_in  = cnt_ff < keep_ff;

      ok_new = (cmd_ff == CMD_PUT) || ((cmd_ff == CMD_SCROLL) && lines_ok) ||
               ((cmd_ff == CMD_READ) && idx_ok);
      rsp_ok_in   = rsp_ok_ff;
      rsp_word_in = rsp_word_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_new;
         rsp_word_in  = {flags_ff, cur_ff};
         rsp_data_in  = ((cmd_ff == CMD_READ) && idx_ok) ? ram_rdata : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         enter_ff     <= ENTER_RESET;
         tab_ff       <= TAB_RESET;
         bs_ff        <= BS_RESET;
         flags_ff     <= '0;
         sweep_ff     <= 1'b0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         enter_ff     <= enter_in;
         tab_ff       <= tab_in;
         bs_ff        <= bs_in;
         flags_ff     <= flags_in;
         sweep_ff     <= sweep_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      code_ff     <= code_in;
      lines_ff    <= lines_in;
      idx_ff      <= idx_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      keep_ff     <= keep_in;
      shift_ff    <= shift_in;
      waddr_ff    <= waddr_in;
      wsrc_ff     <= wsrc_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_word_ff <= rsp_word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ok_ff;
   assign rsp_cursor_word = rsp_word_ff;
   assign rsp_cell_data   = rsp_data_ff;

endmodule

>>> hw/rtl/tcw_checker.sv
// Port-level checks of the text console character writer, bound to the top level.
module tcw_checker import tcw_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   a_data_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63:32] != '0) |-> rsp_tuser)
      else $error("cell data on a rejected beat");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> CW'(rsp_tdata[POS_W-1:0]) < CW'(CELLS))
      else $error("cursor beyond the screen");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
